[rtl/core/module_presence_table_unit_assert.svh]
// Assertion macros for the presence table unit
`ifndef MODULE_PRESENCE_TABLE_UNIT_ASSERT_SVH
`define MODULE_PRESENCE_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define MPT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("presence table check failed");

// next-cycle implication, sampled on clock, off during reset
`define MPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("presence table check failed");

`endif

[rtl/core/mpt_pkg.sv]
// Types and constants shared by the presence table unit
`timescale 1ns / 1ps
package mpt_pkg;

   localparam logic [2:0] CMD_ADD_OR_UPDATE = 3'd0;
   localparam logic [2:0] CMD_MARK_ONLINE   = 3'd1;
   localparam logic [2:0] CMD_MARK_OFFLINE  = 3'd2;
   localparam logic [2:0] CMD_SET_TYPE      = 3'd3;
   localparam logic [2:0] CMD_LOOKUP        = 3'd4;
   localparam logic [2:0] CMD_CLEAR         = 3'd5;

   localparam logic [1:0] ST_UNKNOWN = 2'd0;
   localparam logic [1:0] ST_OFFLINE = 2'd1;
   localparam logic [1:0] ST_ONLINE  = 2'd2;

   localparam logic [2:0] TYPE_UNKNOWN = 3'd0;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_DISCOVERED = 3'd1;
   localparam logic [2:0] EV_UPDATED    = 3'd2;
   localparam logic [2:0] EV_ONLINE     = 3'd3;
   localparam logic [2:0] EV_OFFLINE    = 3'd4;

   typedef struct packed {
      logic [7:0]  address;
      logic [2:0]  module_type;
      logic [1:0]  status;
      logic [31:0] seen_ms;
   } mpt_entry_type;

   typedef enum logic {
      MPT_IDLE,
      MPT_SCAN
   } mpt_state_type;

endpackage

[rtl/core/mpt_ram.sv]
// Entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module mpt_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  mpt_pkg::mpt_entry_type wr_data,
   input  logic [AW-1:0]         rd_addr,
   output mpt_pkg::mpt_entry_type rd_data
);
   import mpt_pkg::*;

   mpt_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/module_presence_table_unit.sv]
// Top level of the module presence table
`timescale 1ns / 1ps
`include "module_presence_table_unit_assert.svh"
// Address-keyed table of bus modules held in one synchronous memory. A command is taken
// when start is high and busy is low; busy then stays high until the result word is
// presented. The table is searched slot by slot through the memory read port, one slot a
// cycle, until the address is found or the last entry is compared; clear and an unknown
// command need no search. Each result is shown for one cycle with rsp_valid and must be
// taken then: the receiver cannot stall. Online and offline totals are kept as running
// counters, so no scan is needed to report them.
module module_presence_table_unit #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_address,
   input  logic [2:0]  req_module_type,
   input  logic [1:0]  req_new_status,
   input  logic [31:0] req_timestamp_ms,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_was_added,
   output logic [2:0]  rsp_entry_type,
   output logic [1:0]  rsp_entry_status,
   output logic [31:0] rsp_entry_seen_ms,
   output logic [4:0]  rsp_entry_count,
   output logic [4:0]  rsp_online_count,
   output logic        rsp_any_offline
);
   import mpt_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   mpt_state_type state_ff, state_in;

   logic [2:0]  cmd_ff;
   logic [7:0]  addr_ff;
   logic [2:0]  type_ff;
   logic [1:0]  status_ff;
   logic [31:0] ts_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] online_ff, online_in;
   logic [CW-1:0] offline_ff, offline_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;

   logic          rsp_valid_ff, rsp_ok_ff, rsp_added_ff;
   logic [2:0]    rsp_event_ff;
   mpt_entry_type rsp_entry_ff;
   logic [CW-1:0] rsp_count_ff, rsp_online_ff;
   logic          rsp_offline_ff;

   logic          accept;
   logic          decide;
   logic          hit, miss, room, last;
   logic          do_write, append, show, ok, added;
   logic [2:0]    ev;
   logic [AW-1:0] wr_idx;
   mpt_entry_type rd_data, new_e;
   logic          old_on, old_off, new_on, new_off;
   logic [CW+4:0] count_w, online_w;

   mpt_ram #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_idx),
      .wr_data (new_e),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign accept = start && !busy;
   assign hit    = rd_vld_ff && (rd_data.address == addr_ff);
   assign last   = (CW'(chk_idx_ff) + CW'(1)) == count_ff;
   assign miss   = !hit && ((count_ff == '0) || (rd_vld_ff && last));
   assign room   = count_ff < CW'(MAX_ENTRIES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MPT_IDLE: begin
            if (start) state_in = MPT_SCAN;
         end
         MPT_SCAN: begin
            if (decide) state_in = MPT_IDLE;
         end
         default: state_in = MPT_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy = (state_ff == MPT_SCAN);
   end

   // search decision and read-modify-write of the addressed entry
   always_comb begin
      decide     = 1'b0;
      do_write   = 1'b0;
      append     = 1'b0;
      show       = 1'b0;
      ok         = 1'b0;
      added      = 1'b0;
      ev         = EV_NONE;
      new_e      = rd_data;
      wr_idx     = hit ? chk_idx_ff : count_ff[AW-1:0];
      count_in   = count_ff;
      online_in  = online_ff;
      offline_in = offline_ff;
      if (state_ff == MPT_SCAN) begin
         case (cmd_ff)
            CMD_CLEAR: begin
               decide     = 1'b1;
               ok         = 1'b1;
               count_in   = '0;
               online_in  = '0;
               offline_in = '0;
            end
            CMD_ADD_OR_UPDATE, CMD_MARK_ONLINE, CMD_MARK_OFFLINE, CMD_SET_TYPE,
            CMD_LOOKUP: begin
               decide = hit || miss;
               if (hit || miss) begin
                  case (cmd_ff)
                     CMD_ADD_OR_UPDATE: begin
                        if (hit) begin
                           new_e    = '{rd_data.address, type_ff, status_ff, ts_ff};
                           do_write = 1'b1;
                           ok       = 1'b1;
                           ev       = EV_UPDATED;
                        end else if (room) begin
                           new_e    = '{addr_ff, type_ff, status_ff, ts_ff};
                           do_write = 1'b1;
                           append   = 1'b1;
                           ok       = 1'b1;
                           added    = 1'b1;
                           ev       = EV_DISCOVERED;
                        end
                     end
                     CMD_MARK_ONLINE: begin
                        if (hit) begin
                           new_e.status  = ST_ONLINE;
                           new_e.seen_ms = ts_ff;
                           do_write      = 1'b1;
                           ok            = 1'b1;
                           ev            = EV_ONLINE;
                        end else if (room) begin
                           new_e    = '{addr_ff, type_ff, ST_ONLINE, ts_ff};
                           do_write = 1'b1;
                           append   = 1'b1;
                           ok       = 1'b1;
                           added    = 1'b1;
                           ev       = EV_ONLINE;
                        end
                     end
                     CMD_MARK_OFFLINE: begin
                        if (hit) begin
                           new_e.status = ST_OFFLINE;
                           do_write     = 1'b1;
                           ok           = 1'b1;
                           ev           = EV_OFFLINE;
                        end
                     end
                     CMD_SET_TYPE: begin
                        if (hit) begin
                           if (type_ff != TYPE_UNKNOWN) new_e.module_type = type_ff;
                           do_write = 1'b1;
                           ok       = 1'b1;
                           ev       = EV_UPDATED;
                        end
                     end
                     default: begin
                        ok = hit;
                     end
                  endcase
                  show = ok;
               end
            end
            default: begin
               decide = 1'b1;
            end
         endcase
      end

      old_on  = hit && (rd_data.status == ST_ONLINE);
      old_off = hit && (rd_data.status == ST_OFFLINE);
      new_on  = new_e.status == ST_ONLINE;
      new_off = new_e.status == ST_OFFLINE;
      if (do_write) begin
         online_in  = online_ff + CW'(new_on) - CW'(old_on);
         offline_in = offline_ff + CW'(new_off) - CW'(old_off);
      end
      if (append) count_in = count_ff + CW'(1);
   end

   // read pointer runs ahead of the compare by the registered memory read
   always_comb begin
      rd_idx_in  = rd_idx_ff;
      chk_idx_in = rd_idx_ff[AW-1:0];
      rd_vld_in  = 1'b0;
      if (accept) begin
         rd_idx_in = '0;
      end else if (busy && !decide) begin
         rd_vld_in = rd_idx_ff < count_ff;
         if (rd_idx_ff < count_ff) rd_idx_in = rd_idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MPT_IDLE;
         count_ff     <= '0;
         online_ff    <= '0;
         offline_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         online_ff    <= online_in;
         offline_ff   <= offline_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= decide;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      if (accept) begin
         cmd_ff    <= req_cmd;
         addr_ff   <= req_address;
         type_ff   <= req_module_type;
         status_ff <= req_new_status;
         ts_ff     <= req_timestamp_ms;
      end
      if (decide) begin
         rsp_ok_ff      <= ok;
         rsp_added_ff   <= added;
         rsp_event_ff   <= ev;
         rsp_entry_ff   <= show ? new_e : '0;
         rsp_count_ff   <= count_in;
         rsp_online_ff  <= online_in;
         rsp_offline_ff <= offline_in != '0;
      end
   end

   // counts reported modulo 32
   assign count_w  = {5'd0, rsp_count_ff};
   assign online_w = {5'd0, rsp_online_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_event_code    = rsp_event_ff;
   assign rsp_was_added     = rsp_added_ff;
   assign rsp_entry_type    = rsp_entry_ff.module_type;
   assign rsp_entry_status  = rsp_entry_ff.status;
   assign rsp_entry_seen_ms = rsp_entry_ff.seen_ms;
   assign rsp_entry_count   = count_w[4:0];
   assign rsp_online_count  = online_w[4:0];
   assign rsp_any_offline   = rsp_offline_ff;

   `MPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `MPT_ASSERT_IMPL(a_rsp_idle, rsp_valid, !busy)
   `MPT_ASSERT_IMPL(a_counts_fit, 1'b1, (({1'b0, online_ff} + {1'b0, offline_ff}) <= {1'b0, count_ff}))
   `MPT_ASSERT_IMPL(a_added_event, rsp_valid && rsp_was_added, rsp_ok && (rsp_event_code == EV_DISCOVERED || rsp_event_code == EV_ONLINE))

endmodule

[test/module_presence_table_unit_tb.sv]
// Self-checking testbench for the module presence table unit
`timescale 1ns / 1ps
module module_presence_table_unit_tb;
   import mpt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_WORDS = 700;
   localparam int QUIET_WORDS = 150;
   localparam logic [2:0] CMD_RESERVED_A = 3'd6;
   localparam logic [2:0] CMD_RESERVED_B = 3'd7;
   localparam logic [7:0] POOL_BASE = 8'h10;

   typedef struct packed {
      logic        ok;
      logic [2:0]  event_code;
      logic        was_added;
      logic [2:0]  entry_type;
      logic [1:0]  entry_status;
      logic [31:0] entry_seen_ms;
      logic [4:0]  entry_count;
      logic [4:0]  online_count;
      logic        any_offline;
   } presence_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_cmd = CMD_LOOKUP;
   logic [7:0]  req_address = '0;
   logic [2:0]  req_module_type = TYPE_UNKNOWN;
   logic [1:0]  req_new_status = ST_UNKNOWN;
   logic [31:0] req_timestamp_ms = '0;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [2:0]  rsp_event_code;
   logic        rsp_was_added;
   logic [2:0]  rsp_entry_type;
   logic [1:0]  rsp_entry_status;
   logic [31:0] rsp_entry_seen_ms;
   logic [4:0]  rsp_entry_count;
   logic [4:0]  rsp_online_count;
   logic        rsp_any_offline;

   // shadow copy of the table
   logic [7:0]  tbl_addr [TABLE_DEPTH];
   logic [2:0]  tbl_type [TABLE_DEPTH];
   logic [1:0]  tbl_status [TABLE_DEPTH];
   logic [31:0] tbl_seen [TABLE_DEPTH];
   int          tbl_count = 0;

   presence_report_type pending_reports[$];

   int  mismatches = 0;
   int  words_sent = 0;
   int  reports_checked = 0;
   int  full_rejects = 0;
   int  clears_sent = 0;
   int  cycle_count = 0;
   bit  sender_idles = 1'b0;

   module_presence_table_unit #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_address       (req_address),
      .req_module_type   (req_module_type),
      .req_new_status    (req_new_status),
      .req_timestamp_ms  (req_timestamp_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_event_code    (rsp_event_code),
      .rsp_was_added     (rsp_was_added),
      .rsp_entry_type    (rsp_entry_type),
      .rsp_entry_status  (rsp_entry_status),
      .rsp_entry_seen_ms (rsp_entry_seen_ms),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_online_count  (rsp_online_count),
      .rsp_any_offline   (rsp_any_offline)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d result words outstanding", $time,
                  pending_reports.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic predict_presence(input logic [2:0] cmd, input logic [7:0] addr,
                                   input logic [2:0] mtype, input logic [1:0] status,
                                   input logic [31:0] ts);
      presence_report_type rep;
      int slot;
      int n_online;
      logic off_seen;
      rep = '0;
      slot = -1;
      n_online = 0;
      off_seen = 1'b0;
      for (int i = 0; i < tbl_count; i++)
         if (slot < 0 && tbl_addr[i] == addr) slot = i;
      case (cmd)
         CMD_ADD_OR_UPDATE, CMD_MARK_ONLINE: begin
            if (slot >= 0) begin
               if (cmd == CMD_ADD_OR_UPDATE) begin
                  tbl_type[slot] = mtype;
                  tbl_status[slot] = status;
                  rep.event_code = EV_UPDATED;
               end else begin
                  tbl_status[slot] = ST_ONLINE;
                  rep.event_code = EV_ONLINE;
               end
               tbl_seen[slot] = ts;
               rep.ok = 1'b1;
            end else if (tbl_count < TABLE_DEPTH) begin
               slot = tbl_count;
               tbl_addr[slot] = addr;
               tbl_type[slot] = mtype;
               tbl_status[slot] = (cmd == CMD_ADD_OR_UPDATE) ? status : ST_ONLINE;
               tbl_seen[slot] = ts;
               tbl_count++;
               rep.ok = 1'b1;
               rep.was_added = 1'b1;
               rep.event_code = (cmd == CMD_ADD_OR_UPDATE) ? EV_DISCOVERED : EV_ONLINE;
            end else begin
               full_rejects++;
            end
         end
         CMD_MARK_OFFLINE: begin
            if (slot >= 0) begin
               tbl_status[slot] = ST_OFFLINE;
               rep.ok = 1'b1;
               rep.event_code = EV_OFFLINE;
            end
         end
         CMD_SET_TYPE: begin
            if (slot >= 0) begin
               if (mtype != TYPE_UNKNOWN) tbl_type[slot] = mtype;
               rep.ok = 1'b1;
               rep.event_code = EV_UPDATED;
            end
         end
         CMD_LOOKUP: begin
            if (slot >= 0) rep.ok = 1'b1;
         end
         CMD_CLEAR: begin
            tbl_count = 0;
            slot = -1;
            rep.ok = 1'b1;
         end
         default: begin
            slot = -1;
         end
      endcase
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_status[i] == ST_ONLINE) n_online++;
         if (tbl_status[i] == ST_OFFLINE) off_seen = 1'b1;
      end
      if (slot >= 0) begin
         rep.entry_type = tbl_type[slot];
         rep.entry_status = tbl_status[slot];
         rep.entry_seen_ms = tbl_seen[slot];
      end
      rep.entry_count = 5'(tbl_count);
      rep.online_count = 5'(n_online);
      rep.any_offline = off_seen;
      pending_reports.push_back(rep);
   endtask

   task automatic send_word(input logic [2:0] cmd, input logic [7:0] addr,
                            input logic [2:0] mtype, input logic [1:0] status,
                            input logic [31:0] ts);
      @(negedge clock);
      start <= 1'b1;
      req_cmd <= cmd;
      req_address <= addr;
      req_module_type <= mtype;
      req_new_status <= status;
      req_timestamp_ms <= ts;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_presence(cmd, addr, mtype, status, ts);
      words_sent++;
      if (cmd == CMD_CLEAR) clears_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic maybe_pause();
      if (sender_idles && $urandom_range(99) < 20) begin
         if ($urandom_range(3) == 0) pause_sender($urandom_range(5, 20));
         else pause_sender($urandom_range(1, 4));
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      presence_report_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result word with nothing expected, actual ok %0b event %0d",
                     $time, rsp_ok, rsp_event_code);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            check_field("ok", 32'(want.ok), 32'(rsp_ok));
            check_field("event_code", 32'(want.event_code), 32'(rsp_event_code));
            check_field("was_added", 32'(want.was_added), 32'(rsp_was_added));
            check_field("entry_type", 32'(want.entry_type), 32'(rsp_entry_type));
            check_field("entry_status", 32'(want.entry_status), 32'(rsp_entry_status));
            check_field("entry_seen_ms", want.entry_seen_ms, rsp_entry_seen_ms);
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            check_field("online_count", 32'(want.online_count), 32'(rsp_online_count));
            check_field("any_offline", 32'(want.any_offline), 32'(rsp_any_offline));
         end
      end
   end

   task automatic test_directed_commands();
      send_word(CMD_LOOKUP, 8'h00, TYPE_UNKNOWN, ST_UNKNOWN, 32'h0);
      send_word(CMD_MARK_OFFLINE, 8'h42, TYPE_UNKNOWN, ST_UNKNOWN, 32'h0);
      send_word(CMD_SET_TYPE, 8'h42, 3'd3, ST_UNKNOWN, 32'h0);
      send_word(CMD_ADD_OR_UPDATE, 8'h00, 3'd1, ST_ONLINE, 32'h0);
      send_word(CMD_ADD_OR_UPDATE, 8'hFF, 3'd7, 2'd3, 32'hFFFF_FFFF);
      send_word(CMD_ADD_OR_UPDATE, 8'h00, 3'd5, ST_OFFLINE, 32'h8000_0000);
      send_word(CMD_MARK_ONLINE, 8'hFF, 3'd2, ST_UNKNOWN, 32'h0000_3039);
      send_word(CMD_MARK_ONLINE, 8'hA5, 3'd6, 2'd3, 32'h5A5A_5A5A);
      send_word(CMD_MARK_OFFLINE, 8'hA5, TYPE_UNKNOWN, ST_UNKNOWN, 32'h0);
      send_word(CMD_SET_TYPE, 8'hA5, TYPE_UNKNOWN, ST_UNKNOWN, 32'h0);
      send_word(CMD_SET_TYPE, 8'hA5, 3'd4, ST_UNKNOWN, 32'h0);
      send_word(CMD_LOOKUP, 8'hFF, 3'd7, 2'd3, 32'hFFFF_FFFF);
      send_word(CMD_RESERVED_A, 8'h00, 3'd1, ST_ONLINE, 32'h1);
      send_word(CMD_RESERVED_B, 8'hFF, 3'd7, 2'd3, 32'hFFFF_FFFF);
      send_word(CMD_ADD_OR_UPDATE, 8'h01, 3'd2, ST_UNKNOWN, 32'h7FFF_FFFF);
      send_word(CMD_CLEAR, 8'h00, TYPE_UNKNOWN, ST_UNKNOWN, 32'h0);
      send_word(CMD_LOOKUP, 8'h00, TYPE_UNKNOWN, ST_UNKNOWN, 32'h0);
      wait_for_results();
   endtask

   task automatic test_table_full();
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_word((i % 2) ? CMD_MARK_ONLINE : CMD_ADD_OR_UPDATE, POOL_BASE + 8'(i),
                   3'($urandom_range(1, 5)), 2'($urandom_range(0, 2)), $urandom());
      send_word(CMD_ADD_OR_UPDATE, 8'hEE, 3'd3, ST_ONLINE, 32'h1234_5678);
      send_word(CMD_MARK_ONLINE, 8'hEF, 3'd4, ST_UNKNOWN, 32'h8765_4321);
      send_word(CMD_MARK_OFFLINE, POOL_BASE + 8'(TABLE_DEPTH - 1), TYPE_UNKNOWN,
                ST_UNKNOWN, 32'h0);
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int useful;
      int pick;
      logic [2:0] cmd;
      logic [7:0] addr;
      logic [2:0] mtype;
      logic [1:0] status;
      useful = 0;
      while (useful < RANDOM_WORDS) begin
         sender_idles = (useful >= QUIET_WORDS);
         pick = $urandom_range(99);
         if (pick < 25) cmd = CMD_ADD_OR_UPDATE;
         else if (pick < 45) cmd = CMD_MARK_ONLINE;
         else if (pick < 60) cmd = CMD_MARK_OFFLINE;
         else if (pick < 75) cmd = CMD_SET_TYPE;
         else if (pick < 94) cmd = CMD_LOOKUP;
         else if (pick < 97) cmd = CMD_CLEAR;
         else cmd = ($urandom_range(1)) ? CMD_RESERVED_B : CMD_RESERVED_A;
         // small address pool so hits dominate and the table fills up
         pick = $urandom_range(99);
         if (pick < 5) addr = 8'h00;
         else if (pick < 10) addr = 8'hFF;
         else if (pick < 85) addr = POOL_BASE + 8'($urandom_range(19));
         else addr = 8'($urandom_range(255));
         mtype = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
         status = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         maybe_pause();
         send_word(cmd, addr, mtype, status, $urandom());
         if (cmd != CMD_RESERVED_A && cmd != CMD_RESERVED_B) useful++;
      end
      sender_idles = 1'b0;
      wait_for_results();
   endtask

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_table_full();
      test_random_traffic();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d command words and checked %0d result words.", words_sent,
               reports_checked);
      $display("Clears issued: %0d, appends refused on a full table: %0d.", clears_sent,
               full_rejects);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
